// ----- hw/rtl/eth_lbi_pkg.sv -----
// Package for the Ethernet OAM loopback initiator.
// Holds opcodes, drop reasons, register indexes and the saturating counter helper.
// No dependencies.
package eth_lbi_pkg;

	localparam int unsigned MAC_W   = 48;
	localparam int unsigned VID_W   = 12;
	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned TID_W   = 32;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned CFG_W   = 48;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [7:0]       LBR_OPCODE = 8'd2;
	localparam logic [CNT_W-1:0] CNT_MAX    = 16'hffff;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_FRAME = 1'b1
	} item_op_t;

	typedef enum logic [2:0] {
		DROP_NONE    = 3'd0,
		DROP_ADDRESS = 3'd1,
		DROP_VLAN    = 3'd2,
		DROP_OPCODE  = 3'd3,
		DROP_LEVEL   = 3'd4,
		DROP_TRANS   = 3'd5
	} drop_reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCAL_MAC    = 3'd0,
		REG_MEG_LEVEL    = 3'd1,
		REG_SESSION_VLAN = 3'd2,
		REG_CUSTOM_TAG   = 3'd3,
		REG_MCAST_MODE   = 3'd4,
		REG_MISSED_THR   = 3'd5,
		REG_RECOVERY_THR = 3'd6,
		REG_ONESHOT      = 3'd7
	} cfg_reg_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

// ----- hw/rtl/eth_loopback_initiator.sv -----
// Ethernet OAM loopback initiator: tick and reply-frame handling with a registered result.
// Depends on eth_lbi_pkg.
// The result is registered and valid in the cycle after input acceptance.
// Throughput: one word per cycle; the single result register stalls intake only while
// a result waits and the sink is not ready.
// Reset (arst_n low, asynchronous): session running, no request outstanding, transaction
// id 0, all counters and configuration registers 0, result register empty.
module eth_loopback_initiator
	import eth_lbi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [MAC_W-1:0]     dest_mac,
	input  logic                 frame_tagged,
	input  logic [VID_W-1:0]     tag_vid,
	input  logic [7:0]           header_level_byte,
	input  logic [7:0]           pdu_opcode,
	input  logic [TID_W-1:0]     frame_trans_id,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 send_request,
	output logic [TID_W-1:0]     request_id,
	output logic                 timed_out,
	output logic                 reply_matched,
	output logic [2:0]           drop_reason,
	output logic                 missed_alarm,
	output logic                 recovered_alarm,
	output logic                 session_stopped,
	output logic [CNT_W-1:0]     multicast_reply_count
);

	// configuration registers
	logic [MAC_W-1:0]   local_mac_q;
	logic [LEVEL_W-1:0] meg_level_q;
	logic [VID_W-1:0]   session_vlan_q;
	logic               custom_tag_q;
	logic               mcast_mode_q;
	logic [CNT_W-1:0]   missed_thr_q;
	logic [CNT_W-1:0]   recovery_thr_q;
	logic               oneshot_q;

	// session state
	logic             stopped_q;
	logic             reply_seen_q;
	logic [TID_W-1:0] current_id_q;
	logic [CNT_W-1:0] miss_count_q;
	logic [CNT_W-1:0] reply_count_q;
	logic             is_recovered_q;
	logic [CNT_W-1:0] mcast_replies_q;

	// next state
	logic             stopped_d;
	logic             reply_seen_d;
	logic [TID_W-1:0] current_id_d;
	logic [CNT_W-1:0] miss_count_d;
	logic [CNT_W-1:0] reply_count_d;
	logic             is_recovered_d;
	logic [CNT_W-1:0] mcast_replies_d;

	// result of the current word
	logic         send_d;
	logic         tout_d;
	logic         match_d;
	drop_reason_t drop_d;
	logic         malarm_d;
	logic         ralarm_d;

	// result register
	logic             valid_s1;
	logic             send_s1;
	logic [TID_W-1:0] id_s1;
	logic             tout_s1;
	logic             match_s1;
	drop_reason_t     drop_s1;
	logic             malarm_s1;
	logic             ralarm_s1;
	logic             stopped_s1;
	logic [CNT_W-1:0] mcast_s1;

	logic               accept;
	logic               unicast_miss;
	logic [CNT_W-1:0]   miss_inc;
	logic [CNT_W-1:0]   reply_inc;
	logic [CNT_W-1:0]   miss_thr;
	logic [CNT_W-1:0]   rec_thr;
	logic               one_eff;
	logic               tag_eff;
	logic [LEVEL_W-1:0] frame_level;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// multicast mode masks thresholds, one-shot and own tagging
	assign miss_thr = mcast_mode_q ? '0 : missed_thr_q;
	assign rec_thr  = mcast_mode_q ? '0 : recovery_thr_q;
	assign one_eff  = !mcast_mode_q && oneshot_q;
	assign tag_eff  = !mcast_mode_q && custom_tag_q;

	assign frame_level  = header_level_byte[7:5];
	assign unicast_miss = !reply_seen_q && !mcast_mode_q;
	assign miss_inc     = unicast_miss ? sat_inc(miss_count_q) : miss_count_q;
	assign reply_inc    = sat_inc(reply_count_q);

	always_comb begin
		stopped_d       = stopped_q;
		reply_seen_d    = reply_seen_q;
		current_id_d    = current_id_q;
		miss_count_d    = miss_count_q;
		reply_count_d   = reply_count_q;
		is_recovered_d  = is_recovered_q;
		mcast_replies_d = mcast_replies_q;
		send_d          = 1'b0;
		tout_d          = 1'b0;
		match_d         = 1'b0;
		drop_d          = DROP_NONE;
		malarm_d        = 1'b0;
		ralarm_d        = 1'b0;

		if (!stopped_q) begin
			if (item_op_t'(opcode) == OP_TICK) begin
				tout_d       = !reply_seen_q;
				reply_seen_d = 1'b0;
				if (unicast_miss) begin
					reply_count_d  = '0;
					is_recovered_d = 1'b0;
				end
				if (!reply_seen_q && mcast_mode_q) begin
					mcast_replies_d = '0;
				end
				miss_count_d = miss_inc;
				if ((miss_thr != '0) && (miss_inc == miss_thr)) begin
					malarm_d     = 1'b1;
					miss_count_d = '0;
					stopped_d    = one_eff;
				end
				// no new request once the one-shot alarm stops the session
				if (!(malarm_d && one_eff)) begin
					current_id_d = current_id_q + 32'd1;
					send_d       = 1'b1;
				end
			end else begin
				if (dest_mac != local_mac_q) begin
					drop_d = DROP_ADDRESS;
				end else if (frame_tagged && (!tag_eff || tag_vid != session_vlan_q)) begin
					drop_d = DROP_VLAN;
				end else if (pdu_opcode != LBR_OPCODE) begin
					drop_d = DROP_OPCODE;
				end else if (frame_level != meg_level_q) begin
					drop_d = DROP_LEVEL;
				end else if (frame_trans_id != current_id_q) begin
					drop_d = DROP_TRANS;
				end else begin
					match_d       = 1'b1;
					miss_count_d  = '0;
					reply_count_d = reply_inc;
					reply_seen_d  = 1'b1;
					if (mcast_mode_q) begin
						mcast_replies_d = sat_inc(mcast_replies_q);
					end
					if ((rec_thr != '0) && !is_recovered_q && (rec_thr == reply_inc)) begin
						is_recovered_d = 1'b1;
						ralarm_d       = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q    <= '0;
			meg_level_q    <= '0;
			session_vlan_q <= '0;
			custom_tag_q   <= 1'b0;
			mcast_mode_q   <= 1'b0;
			missed_thr_q   <= '0;
			recovery_thr_q <= '0;
			oneshot_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOCAL_MAC:    local_mac_q    <= cfg_wdata[MAC_W-1:0];
				REG_MEG_LEVEL:    meg_level_q    <= cfg_wdata[LEVEL_W-1:0];
				REG_SESSION_VLAN: session_vlan_q <= cfg_wdata[VID_W-1:0];
				REG_CUSTOM_TAG:   custom_tag_q   <= cfg_wdata[0];
				REG_MCAST_MODE:   mcast_mode_q   <= cfg_wdata[0];
				REG_MISSED_THR:   missed_thr_q   <= cfg_wdata[CNT_W-1:0];
				REG_RECOVERY_THR: recovery_thr_q <= cfg_wdata[CNT_W-1:0];
				REG_ONESHOT:      oneshot_q      <= cfg_wdata[0];
				default:          local_mac_q    <= local_mac_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q       <= 1'b0;
			reply_seen_q    <= 1'b1;
			current_id_q    <= '0;
			miss_count_q    <= '0;
			reply_count_q   <= '0;
			is_recovered_q  <= 1'b1;
			mcast_replies_q <= '0;
		end else if (accept) begin
			stopped_q       <= stopped_d;
			reply_seen_q    <= reply_seen_d;
			current_id_q    <= current_id_d;
			miss_count_q    <= miss_count_d;
			reply_count_q   <= reply_count_d;
			is_recovered_q  <= is_recovered_d;
			mcast_replies_q <= mcast_replies_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload holds while the result waits
	always_ff @(posedge clk) begin
		if (accept) begin
			send_s1    <= send_d;
			id_s1      <= current_id_d;
			tout_s1    <= tout_d;
			match_s1   <= match_d;
			drop_s1    <= drop_d;
			malarm_s1  <= malarm_d;
			ralarm_s1  <= ralarm_d;
			stopped_s1 <= stopped_d;
			mcast_s1   <= mcast_replies_d;
		end
	end

	assign out_valid             = valid_s1;
	assign send_request          = send_s1;
	assign request_id            = id_s1;
	assign timed_out             = tout_s1;
	assign reply_matched         = match_s1;
	assign drop_reason           = drop_s1;
	assign missed_alarm          = malarm_s1;
	assign recovered_alarm       = ralarm_s1;
	assign session_stopped       = stopped_s1;
	assign multicast_reply_count = mcast_s1;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	a_stop_is_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped session restarted");

	a_tick_frame_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((send_request || timed_out || missed_alarm)
			&& (reply_matched || recovered_alarm)))
		else $error("result mixes tick and frame fields");

	a_match_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reply_matched) |-> (drop_s1 == DROP_NONE))
		else $error("matched reply carries a drop reason");

	a_send_advances_id: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && send_d) |=> (current_id_q == $past(current_id_q) + 32'd1))
		else $error("request issued without a new transaction id");

endmodule
